### rtl/dubd_pkg.sv
`timescale 1ns / 1ps

package dubd_pkg;

  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam int MAX_RES = 3;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_MID   = 3'd1,
    PH_DOT   = 3'd2,
    PH_DOTCR = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       body_end;
    logic       terminator_seen;
    logic       run_last;
  } res_t;

endpackage

### rtl/dubd_step.sv
`timescale 1ns / 1ps

module dubd_step
  import dubd_pkg::*;
(
  input  phase_t     phase,
  input  logic       unstuff_enable,
  input  logic       kind,
  input  logic [7:0] data_byte,
  output res_t       res [MAX_RES],
  output logic [1:0] res_cnt,
  output phase_t     phase_nxt
);

  always_comb begin
    logic [1:0] n;
    logic       held_dot;
    logic       held_cr;
    res_t       blank;
    blank = '0;
    n = 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = blank;
    end
    held_dot  = (phase == PH_DOT) || (phase == PH_DOTCR);
    held_cr   = (phase == PH_DOTCR);
    phase_nxt = phase;

    if (kind == KIND_END) begin
      if (!unstuff_enable || held_cr) begin
        if (held_dot) begin
          res[n] = '{CH_DOT, 1'b1, 1'b0, 1'b0, 1'b0};
          n = n + 2'd1;
        end
        if (held_cr) begin
          res[n] = '{CH_CR, 1'b1, 1'b0, 1'b0, 1'b0};
          n = n + 2'd1;
        end
      end
      res[n] = '{8'h00, 1'b0, 1'b1,
                 unstuff_enable && (phase == PH_DOT || phase == PH_DONE), 1'b0};
      n = n + 2'd1;
      phase_nxt = PH_START;
    end else if (!unstuff_enable) begin
      if (held_dot) begin
        res[n] = '{CH_DOT, 1'b1, 1'b0, 1'b0, 1'b0};
        n = n + 2'd1;
      end
      if (held_cr) begin
        res[n] = '{CH_CR, 1'b1, 1'b0, 1'b0, 1'b0};
        n = n + 2'd1;
      end
      res[n] = '{data_byte, 1'b1, 1'b0, 1'b0, 1'b0};
      n = n + 2'd1;
      phase_nxt = (data_byte == CH_LF) ? PH_START : PH_MID;
    end else begin
      case (phase)
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        PH_DOT: begin
          if (data_byte == CH_LF) begin
            phase_nxt = PH_DONE;
          end else if (data_byte == CH_CR) begin
            phase_nxt = PH_DOTCR;
          end else begin
            res[0] = '{CH_DOT, 1'b1, 1'b0, 1'b0, 1'b0};
            n = 2'd1;
            if (data_byte != CH_DOT) begin
              res[1] = '{data_byte, 1'b1, 1'b0, 1'b0, 1'b0};
              n = 2'd2;
            end
            phase_nxt = PH_MID;
          end
        end
        PH_DOTCR: begin
          if (data_byte == CH_LF) begin
            phase_nxt = PH_DONE;
          end else begin
            res[0] = '{CH_DOT, 1'b1, 1'b0, 1'b0, 1'b0};
            res[1] = '{CH_CR, 1'b1, 1'b0, 1'b0, 1'b0};
            res[2] = '{data_byte, 1'b1, 1'b0, 1'b0, 1'b0};
            n = 2'd3;
            phase_nxt = PH_MID;
          end
        end
        PH_MID: begin
          res[0] = '{data_byte, 1'b1, 1'b0, 1'b0, 1'b0};
          n = 2'd1;
          phase_nxt = (data_byte == CH_LF) ? PH_START : PH_MID;
        end
        default: begin
          if (data_byte == CH_DOT) begin
            phase_nxt = PH_DOT;
          end else begin
            res[0] = '{data_byte, 1'b1, 1'b0, 1'b0, 1'b0};
            n = 2'd1;
            phase_nxt = (data_byte == CH_LF) ? PH_START : PH_MID;
          end
        end
      endcase
    end

    // mark the last word of this item
    case (n)
      2'd1:    res[0].run_last = 1'b1;
      2'd2:    res[1].run_last = 1'b1;
      2'd3:    res[2].run_last = 1'b1;
      default: ;
    endcase
    res_cnt = n;
  end

endmodule

### rtl/dot_unstuff_body_decoder_top.sv
`timescale 1ns / 1ps
// Result words are registered in a four-word result queue before they reach the output.
// Throughput: one input word per cycle when in_tready is high; each word yields zero to
// three result words, drained one per cycle from the queue while out_tready is high.
// in_tready is high while the queue holds at most one word, so a full burst always fits.
// Reset (rst_n low, synchronous): line phase to line start, unstuffing on, queue empty.

module dot_unstuff_body_decoder_top
  import dubd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,     // unstuff_enable
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,     // [7:0] data_byte
  input  logic       in_tuser,     // [0] kind
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,    // [7:0] out_byte
  output logic [2:0] out_tuser,    // [0] byte_valid, [1] body_end, [2] terminator_seen
  output logic       out_tlast     // run_last
);

  localparam int QDEPTH = 4;

  logic       enable_r;
  phase_t     phase_r;
  phase_t     phase_nxt;
  res_t       q_r [QDEPTH];
  logic [1:0] wr_ptr_r;
  logic [1:0] rd_ptr_r;
  logic [2:0] cnt_r;
  logic [2:0] cnt_nxt;
  res_t       res [MAX_RES];
  logic [1:0] res_cnt;
  logic [1:0] push_n;
  logic       in_acc;
  logic       pop;
  res_t       head;

  dubd_step u_step (
    .phase          (phase_r),
    .unstuff_enable (enable_r),
    .kind           (in_tuser),
    .data_byte      (in_tdata),
    .res            (res),
    .res_cnt        (res_cnt),
    .phase_nxt      (phase_nxt)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (cnt_r <= 3'd1);
  assign in_acc     = in_tvalid && in_tready;
  assign push_n     = in_acc ? res_cnt : 2'd0;
  assign out_tvalid = (cnt_r != 3'd0);
  assign pop        = out_tvalid && out_tready;
  assign cnt_nxt    = cnt_r + {1'b0, push_n} - {2'b00, pop};

  assign head      = q_r[rd_ptr_r];
  assign out_tdata = head.out_byte;
  assign out_tuser = {head.terminator_seen, head.body_end, head.byte_valid};
  assign out_tlast = head.run_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      phase_r  <= PH_START;
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        enable_r <= cfg_data;
      end
      if (in_acc) begin
        phase_r <= phase_nxt;
      end
      wr_ptr_r <= wr_ptr_r + push_n;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push_n) begin
        q_r[wr_ptr_r + 2'(i)] <= res[i];
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (cnt_r + {1'b0, res_cnt}) <= 3'(QDEPTH))
    else $error("result queue overflow");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(QDEPTH))
    else $error("queue count out of range");

  a_end_to_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == KIND_END) |=> (phase_r == PH_START))
    else $error("end word did not return phase to line start");

  a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == KIND_END) |-> (res_cnt != 2'd0))
    else $error("end word produced no marker");

endmodule

### tb/sv/dot_unstuff_body_decoder_top_tb.sv
`timescale 1ns / 1ps

import dubd_pkg::*;

class body_scoreboard;
  res_t   expected_q[$];
  res_t   burst_q[$];
  phase_t phase;
  logic   unstuff_on;
  int     errors;

  function new();
    phase      = PH_START;
    unstuff_on = 1'b1;
    errors     = 0;
  endfunction

  function void set_enable(logic v);
    unstuff_on = v;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void put(logic [7:0] d, logic valid, logic fin, logic term);
    res_t r;
    r.out_byte        = d;
    r.byte_valid      = valid;
    r.body_end        = fin;
    r.terminator_seen = term;
    r.run_last        = 1'b0;
    burst_q.push_back(r);
  endfunction

  function void release_held(phase_t ph);
    if (ph == PH_DOT || ph == PH_DOTCR) put(CH_DOT, 1'b1, 1'b0, 1'b0);
    if (ph == PH_DOTCR) put(CH_CR, 1'b1, 1'b0, 1'b0);
  endfunction

  function void note_word(logic kind, logic [7:0] d);
    phase_t ph;
    logic   term;
    ph   = phase;
    term = 1'b0;
    burst_q.delete();
    if (kind == KIND_END) begin
      if (!unstuff_on) begin
        release_held(ph);
      end else if (ph == PH_DOT || ph == PH_DONE) begin
        term = 1'b1;
      end else if (ph == PH_DOTCR) begin
        release_held(ph);
      end
      put(8'h00, 1'b0, 1'b1, term);
      phase = PH_START;
    end else if (!unstuff_on) begin
      release_held(ph);
      put(d, 1'b1, 1'b0, 1'b0);
      phase = (d == CH_LF) ? PH_START : PH_MID;
    end else begin
      case (ph)
        PH_DONE: begin
        end
        PH_DOT: begin
          if (d == CH_LF) begin
            ph = PH_DONE;
          end else if (d == CH_CR) begin
            ph = PH_DOTCR;
          end else if (d == CH_DOT) begin
            put(CH_DOT, 1'b1, 1'b0, 1'b0);
            ph = PH_MID;
          end else begin
            put(CH_DOT, 1'b1, 1'b0, 1'b0);
            put(d, 1'b1, 1'b0, 1'b0);
            ph = PH_MID;
          end
        end
        PH_DOTCR: begin
          if (d == CH_LF) begin
            ph = PH_DONE;
          end else begin
            put(CH_DOT, 1'b1, 1'b0, 1'b0);
            put(CH_CR, 1'b1, 1'b0, 1'b0);
            put(d, 1'b1, 1'b0, 1'b0);
            ph = PH_MID;
          end
        end
        PH_MID: begin
          put(d, 1'b1, 1'b0, 1'b0);
          ph = (d == CH_LF) ? PH_START : PH_MID;
        end
        default: begin
          if (d == CH_DOT) begin
            ph = PH_DOT;
          end else begin
            put(d, 1'b1, 1'b0, 1'b0);
            ph = (d == CH_LF) ? PH_START : PH_MID;
          end
        end
      endcase
      phase = ph;
    end
    if (burst_q.size() > 0) burst_q[burst_q.size() - 1].run_last = 1'b1;
    foreach (burst_q[i]) expected_q.push_back(burst_q[i]);
  endfunction

  task report_mismatch(string what, res_t got, res_t want);
    errors++;
    if (errors <= 50)
      $display("%0t mismatch %s: got %02h v%b e%b t%b l%b, want %02h v%b e%b t%b l%b",
               $realtime, what, got.out_byte, got.byte_valid, got.body_end,
               got.terminator_seen, got.run_last, want.out_byte, want.byte_valid,
               want.body_end, want.terminator_seen, want.run_last);
  endtask

  task check_word(res_t got);
    res_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected word", got, '0);
      return;
    end
    want = expected_q.pop_front();
    if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
        got.body_end !== want.body_end || got.terminator_seen !== want.terminator_seen ||
        got.run_last !== want.run_last)
      report_mismatch("field", got, want);
  endtask
endclass

module dot_unstuff_body_decoder_top_tb;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 80;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } in_word_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tuser;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;

  body_scoreboard sb;
  in_word_t       plan_q[$];
  int             send_idle_pct;
  int             recv_stall_pct;
  logic           pressure_arm = 1'b0;
  logic           rx_hold = 1'b0;
  int             idle_cycles = 0;

  dot_unstuff_body_decoder_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin : rx_holdoff
    wait (pressure_arm);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_word(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got.out_byte        = out_tdata;
        got.byte_valid      = out_tuser[0];
        got.body_end        = out_tuser[1];
        got.terminator_seen = out_tuser[2];
        got.run_last        = out_tlast;
        sb.check_word(got);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add(input logic kind, input logic [7:0] d);
    in_word_t w;
    w.kind = kind;
    w.data = d;
    plan_q.push_back(w);
  endtask

  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(15);
    case (r)
      0: return CH_DOT;
      1: return CH_CR;
      2: return CH_LF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] d;
    do d = 8'($urandom_range(255)); while (d == CH_DOT || d == CH_CR || d == CH_LF);
    return d;
  endfunction

  task automatic add_text();
    repeat ($urandom_range(6)) add(KIND_DATA, text_byte());
  endtask

  task automatic add_line();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2, 3: begin
        add(KIND_DATA, plain_byte());
        add_text();
      end
      4, 5: begin
        add(KIND_DATA, CH_DOT);
        add(KIND_DATA, CH_DOT);
        add_text();
      end
      6: begin
        add(KIND_DATA, CH_DOT);
        add(KIND_DATA, plain_byte());
        add_text();
      end
      7: begin
        add(KIND_DATA, CH_DOT);
        add(KIND_DATA, CH_CR);
        add(KIND_DATA, plain_byte());
        add_text();
      end
      8: repeat ($urandom_range(1, 4)) add(KIND_DATA, 8'($urandom_range(255)));
      default: add(KIND_END, 8'($urandom_range(255)));
    endcase
    if (sel <= 7) begin
      if ($urandom_range(3) == 0) add(KIND_DATA, CH_CR);
      add(KIND_DATA, CH_LF);
    end
  endtask

  task automatic add_body();
    int sel;
    repeat ($urandom_range(1, 4)) add_line();
    sel = $urandom_range(3);
    case (sel)
      0: begin
        add(KIND_DATA, CH_DOT);
        add(KIND_DATA, CH_LF);
      end
      1: begin
        add(KIND_DATA, CH_DOT);
        add(KIND_DATA, CH_CR);
        add(KIND_DATA, CH_LF);
      end
      2: add(KIND_DATA, CH_DOT);
      default: begin
      end
    endcase
    if (sel < 2) repeat ($urandom_range(3)) add(KIND_DATA, 8'($urandom_range(255)));
    add(KIND_END, 8'($urandom_range(255)));
  endtask

  task automatic send_plan();
    in_word_t w;
    while (plan_q.size() > 0) begin
      w = plan_q.pop_front();
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        in_tdata  <= 8'($urandom_range(255));
        in_tuser  <= 1'($urandom_range(1));
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tuser  <= w.kind;
      in_tdata  <= w.data;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic settle();
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_enable(v);
  endtask

  task automatic run_phase(input logic en, input int s_idle, input int r_stall,
                           input int n_words, input bit squeeze);
    settle();
    write_enable(en);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    while (plan_q.size() < n_words) add_body();
    if (squeeze) pressure_arm = 1'b1;
    send_plan();
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = 8'h00;
    in_tuser       = KIND_DATA;
    cfg_valid      = 1'b0;
    cfg_data       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    add(KIND_DATA, 8'h00);
    add(KIND_DATA, CH_LF);
    add(KIND_DATA, CH_DOT);
    add(KIND_DATA, 8'h78);
    add(KIND_DATA, CH_LF);
    add(KIND_DATA, CH_DOT);
    add(KIND_DATA, CH_DOT);
    add(KIND_DATA, 8'hFF);
    add(KIND_DATA, CH_LF);
    add(KIND_DATA, CH_DOT);
    add(KIND_DATA, CH_CR);
    add(KIND_DATA, 8'h79);
    add(KIND_DATA, CH_LF);
    add(KIND_DATA, CH_DOT);
    add(KIND_DATA, CH_CR);
    add(KIND_DATA, CH_LF);
    add(KIND_DATA, 8'h7A);
    add(KIND_END, 8'h00);
    add(KIND_DATA, CH_DOT);
    add(KIND_END, 8'h00);
    add(KIND_DATA, CH_DOT);
    add(KIND_DATA, CH_CR);
    add(KIND_END, 8'h00);
    add(KIND_DATA, CH_DOT);
    add(KIND_DATA, CH_LF);
    add(KIND_END, 8'hFF);
    // hold a dot across the switch to pass-through
    add(KIND_DATA, CH_DOT);
    send_plan();

    run_phase(1'b0, 0, 0, 70, 1'b0);
    run_phase(1'b1, 66, 0, 80, 1'b0);
    run_phase(1'b1, 0, 66, 80, 1'b0);
    run_phase(1'b1, 0, 0, 60, 1'b1);
    run_phase(1'b0, 25, 25, 70, 1'b0);
    run_phase(1'b1, 25, 25, 40, 1'b0);
    settle();

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
rtl/dubd_pkg.sv
rtl/dubd_step.sv
rtl/dot_unstuff_body_decoder_top.sv
tb/sv/dot_unstuff_body_decoder_top_tb.sv
